FILE: rtl/cau_pkg.sv
package cau_pkg;

    localparam int DATA_W        = 16;
    localparam int FRAC_BITS_DEF = 8;
    localparam int MAG_W         = 2 * DATA_W;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_t;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [DATA_W-1:0] a_re;
        logic signed [DATA_W-1:0] a_im;
        logic signed [DATA_W-1:0] b_re;
        logic signed [DATA_W-1:0] b_im;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] res_re;
        logic signed [DATA_W-1:0] res_im;
        logic [1:0]               status;
    } rsp_t;

    // one result part as sign/magnitude plus long-division state
    typedef struct packed {
        logic              neg;
        logic [MAG_W-1:0]  mag;
        logic [MAG_W-1:0]  r;
        logic [DATA_W-1:0] nlow;
        logic [DATA_W-1:0] q;
        logic              ovf;
    } lane_t;

    typedef struct packed {
        op_t              op;
        logic             dz;
        logic [MAG_W-1:0] dm;
        lane_t            re;
        lane_t            im;
    } pipe_t;

endpackage

FILE: rtl/cau_front.sv
module cau_front #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  cau_pkg::req_t  in_data,
    output logic           out_valid,
    output cau_pkg::pipe_t out_data
);

    localparam int W     = cau_pkg::DATA_W;
    localparam int MW    = cau_pkg::MAG_W;
    localparam int NW    = MW + FRAC_BITS;
    localparam int TOP_W = NW - W;
    localparam int CW    = TOP_W + MW;

    // stage 1: products and plain sums
    logic                 v1_reg;
    cau_pkg::op_t         op1_reg;
    logic                 dz1_reg;
    logic signed [MW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [MW-1:0] sq_r_reg, sq_i_reg;
    logic signed [W:0]    s_re_reg, s_im_reg;

    // stage 2: sign/magnitude numerators, divisor magnitude
    logic                 v2_reg;
    cau_pkg::op_t         op2_reg;
    logic                 dz2_reg;
    logic [MW-1:0]        dm2_reg;
    logic                 neg_re_reg, neg_im_reg;
    logic [MW-1:0]        mag_re_reg, mag_im_reg;

    logic                 v3_reg;
    cau_pkg::pipe_t       p3_reg;

    cau_pkg::op_t         op_in;
    logic signed [W:0]    s_re_next, s_im_next;
    logic signed [MW:0]   sr, si;
    cau_pkg::pipe_t       p3_next;

    function automatic cau_pkg::lane_t init_lane(input logic neg, input logic [MW-1:0] mag,
                                                 input logic [MW-1:0] dm);
        cau_pkg::lane_t   l;
        logic [NW-1:0]    n;
        logic [TOP_W-1:0] top;
        n      = NW'(mag) << FRAC_BITS;
        top    = n[NW-1:W];
        l.neg  = neg;
        l.mag  = mag;
        l.ovf  = CW'(top) >= CW'(dm);
        l.r    = l.ovf ? '0 : MW'(top);
        l.nlow = n[W-1:0];
        l.q    = '0;
        return l;
    endfunction

    always_comb
    begin
        op_in = cau_pkg::op_t'(in_data.req_type);
        if (op_in == cau_pkg::OP_SUB)
        begin
            s_re_next = (W+1)'(in_data.a_re) - (W+1)'(in_data.b_re);
            s_im_next = (W+1)'(in_data.a_im) - (W+1)'(in_data.b_im);
        end
        else
        begin
            s_re_next = (W+1)'(in_data.a_re) + (W+1)'(in_data.b_re);
            s_im_next = (W+1)'(in_data.a_im) + (W+1)'(in_data.b_im);
        end
    end

    always_comb
    begin
        case (op1_reg)
            cau_pkg::OP_ADD, cau_pkg::OP_SUB:
            begin
                sr = (MW+1)'(s_re_reg);
                si = (MW+1)'(s_im_reg);
            end
            cau_pkg::OP_MUL:
            begin
                sr = (MW+1)'(p_rr_reg >>> FRAC_BITS) - (MW+1)'(p_ii_reg >>> FRAC_BITS);
                si = (MW+1)'(p_ri_reg >>> FRAC_BITS) + (MW+1)'(p_ir_reg >>> FRAC_BITS);
            end
            default:
            begin
                sr = (MW+1)'(p_rr_reg) + (MW+1)'(p_ii_reg);
                si = (MW+1)'(p_ir_reg) - (MW+1)'(p_ri_reg);
            end
        endcase
    end

    always_comb
    begin
        p3_next.op = op2_reg;
        p3_next.dz = dz2_reg;
        p3_next.dm = dm2_reg;
        p3_next.re = init_lane(neg_re_reg, mag_re_reg, dm2_reg);
        p3_next.im = init_lane(neg_im_reg, mag_im_reg, dm2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        op1_reg    <= op_in;
        dz1_reg    <= (in_data.b_re == '0) && (in_data.b_im == '0);
        p_rr_reg   <= MW'(in_data.a_re) * MW'(in_data.b_re);
        p_ii_reg   <= MW'(in_data.a_im) * MW'(in_data.b_im);
        p_ri_reg   <= MW'(in_data.a_re) * MW'(in_data.b_im);
        p_ir_reg   <= MW'(in_data.a_im) * MW'(in_data.b_re);
        sq_r_reg   <= MW'(in_data.b_re) * MW'(in_data.b_re);
        sq_i_reg   <= MW'(in_data.b_im) * MW'(in_data.b_im);
        s_re_reg   <= s_re_next;
        s_im_reg   <= s_im_next;

        op2_reg    <= op1_reg;
        dz2_reg    <= dz1_reg;
        dm2_reg    <= MW'($unsigned(sq_r_reg) + $unsigned(sq_i_reg));
        neg_re_reg <= sr[MW];
        neg_im_reg <= si[MW];
        mag_re_reg <= sr[MW] ? MW'(-sr) : MW'(sr);
        mag_im_reg <= si[MW] ? MW'(-si) : MW'(si);

        p3_reg     <= p3_next;
    end

    assign out_valid = v3_reg;
    assign out_data  = p3_reg;

endmodule

FILE: rtl/cau_div_step.sv
module cau_div_step (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  cau_pkg::pipe_t in_data,
    output logic           out_valid,
    output cau_pkg::pipe_t out_data
);

    localparam int W  = cau_pkg::DATA_W;
    localparam int MW = cau_pkg::MAG_W;

    logic           v_reg;
    cau_pkg::pipe_t p_reg;
    cau_pkg::pipe_t p_next;

    // one restoring quotient bit
    function automatic cau_pkg::lane_t step(input cau_pkg::lane_t l, input logic [MW-1:0] dm);
        cau_pkg::lane_t o;
        logic [MW:0]    rs;
        logic [MW:0]    d;
        logic           ge;
        o      = l;
        rs     = {l.r, l.nlow[W-1]};
        d      = rs - {1'b0, dm};
        ge     = rs >= {1'b0, dm};
        o.r    = ge ? d[MW-1:0] : rs[MW-1:0];
        o.q    = {l.q[W-2:0], ge};
        o.nlow = {l.nlow[W-2:0], 1'b0};
        return o;
    endfunction

    always_comb
    begin
        p_next    = in_data;
        p_next.re = step(in_data.re, in_data.dm);
        p_next.im = step(in_data.im, in_data.dm);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign out_valid = v_reg;
    assign out_data  = p_reg;

endmodule

FILE: rtl/cau_sat.sv
module cau_sat (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  cau_pkg::pipe_t in_data,
    output logic           done,
    output cau_pkg::rsp_t  rsp
);

    localparam int W  = cau_pkg::DATA_W;
    localparam int MW = cau_pkg::MAG_W;
    localparam logic [MW-1:0] HALF = MW'(1) << (W - 1);

    logic          done_reg;
    cau_pkg::rsp_t rsp_reg;
    cau_pkg::rsp_t rsp_next;
    logic          sat_re, sat_im;

    function automatic logic is_sat(input cau_pkg::lane_t l, input logic isdiv);
        logic [MW-1:0] m;
        m = isdiv ? MW'(l.q) : l.mag;
        if (isdiv && l.ovf)
            return 1'b1;
        return l.neg ? (m > HALF) : (m > HALF - 1'b1);
    endfunction

    function automatic logic signed [W-1:0] sat_val(input cau_pkg::lane_t l, input logic isdiv);
        logic [MW-1:0] m;
        m = isdiv ? MW'(l.q) : l.mag;
        if (is_sat(l, isdiv))
            m = l.neg ? HALF : HALF - 1'b1;
        return l.neg ? -m[W-1:0] : m[W-1:0];
    endfunction

    always_comb
    begin
        sat_re = is_sat(in_data.re, in_data.op == cau_pkg::OP_DIV);
        sat_im = is_sat(in_data.im, in_data.op == cau_pkg::OP_DIV);
        rsp_next.res_re = sat_val(in_data.re, in_data.op == cau_pkg::OP_DIV);
        rsp_next.res_im = sat_val(in_data.im, in_data.op == cau_pkg::OP_DIV);
        rsp_next.status = (sat_re || sat_im) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        if (in_data.op == cau_pkg::OP_DIV && in_data.dz)
        begin
            rsp_next.res_re = '0;
            rsp_next.res_im = '0;
            rsp_next.status = cau_pkg::ST_DZ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

FILE: rtl/complex_arithmetic_unit.sv
// Complex add, subtract, multiply and divide on signed fixed-point operands.
// Fully pipelined: one command per cycle, busy is never raised. Every command
// returns its result on rsp with done high for one cycle, after three front
// stages (products, sums, divider setup), one stage per quotient bit of the
// restoring divider and one saturation stage. The receiver cannot stall;
// results are not held.
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  cau_pkg::req_t cmd,
    output logic          done,
    output cau_pkg::rsp_t rsp
);

    localparam int W = cau_pkg::DATA_W;

    logic           vld [W+1];
    cau_pkg::pipe_t stg [W+1];

    assign busy = 1'b0;

    cau_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .in_data  (cmd),
        .out_valid(vld[0]),
        .out_data (stg[0])
    );

    for (genvar i = 0; i < W; i++)
    begin : g_div
        cau_div_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (vld[i]),
            .in_data  (stg[i]),
            .out_valid(vld[i+1]),
            .out_data (stg[i+1])
        );
    end

    cau_sat u_sat (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(vld[W]),
        .in_data (stg[W]),
        .done    (done),
        .rsp     (rsp)
    );

endmodule

FILE: tb/complex_arithmetic_unit_checker.sv
`timescale 1ns / 1ps

module complex_arithmetic_unit_checker #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  cau_pkg::req_t cmd,
    input  logic          done,
    input  cau_pkg::rsp_t rsp,
    output int            errors,
    output int            pending,
    output int            results_seen
);

    cau_pkg::rsp_t result_queue[$];

    localparam longint MAX_V = (64'sd1 <<< (cau_pkg::DATA_W - 1)) - 1;
    localparam longint MIN_V = -(64'sd1 <<< (cau_pkg::DATA_W - 1));

    function automatic longint floor_shift(longint x);
        return x >>> FRAC_BITS;
    endfunction

    // truncate toward zero
    function automatic longint quot_trunc(longint num, longint den);
        longint n;
        longint q;
        begin
            n = num < 0 ? -num : num;
            q = (n <<< FRAC_BITS) / den;
            return num < 0 ? -q : q;
        end
    endfunction

    function automatic logic [cau_pkg::DATA_W-1:0] clamp(longint v, inout logic sat);
        if (v > MAX_V)
        begin
            sat = 1'b1;
            return MAX_V[cau_pkg::DATA_W-1:0];
        end
        if (v < MIN_V)
        begin
            sat = 1'b1;
            return MIN_V[cau_pkg::DATA_W-1:0];
        end
        return v[cau_pkg::DATA_W-1:0];
    endfunction

    function automatic cau_pkg::rsp_t complex_result(cau_pkg::req_t c);
        longint        ar, ai, br, bi, re, im, mag;
        logic          sat;
        cau_pkg::rsp_t r;
        begin
            ar  = longint'(c.a_re);
            ai  = longint'(c.a_im);
            br  = longint'(c.b_re);
            bi  = longint'(c.b_im);
            sat = 1'b0;
            case (cau_pkg::op_t'(c.req_type))
                cau_pkg::OP_ADD:
                begin
                    re = ar + br;
                    im = ai + bi;
                end
                cau_pkg::OP_SUB:
                begin
                    re = ar - br;
                    im = ai - bi;
                end
                cau_pkg::OP_MUL:
                begin
                    re = floor_shift(ar * br) - floor_shift(ai * bi);
                    im = floor_shift(ar * bi) + floor_shift(ai * br);
                end
                default:
                begin
                    mag = br * br + bi * bi;
                    if (mag == 0)
                    begin
                        r.res_re = '0;
                        r.res_im = '0;
                        r.status = cau_pkg::ST_DZ;
                        return r;
                    end
                    re = quot_trunc(ar * br + ai * bi, mag);
                    im = quot_trunc(ai * br - ar * bi, mag);
                end
            endcase
            r.res_re = clamp(re, sat);
            r.res_im = clamp(im, sat);
            r.status = sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
            return r;
        end
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    initial
    begin
        errors       = 0;
        results_seen = 0;
    end

    assign pending = result_queue.size();

    always @(posedge clk)
    begin
        cau_pkg::rsp_t want;
        if (rst_n)
        begin
            if (start && !busy)
                result_queue.push_back(complex_result(cmd));
            if (done)
            begin
                results_seen++;
                if (result_queue.size() == 0)
                    report_mismatch("unexpected beat", 1, 0);
                else
                begin
                    want = result_queue.pop_front();
                    if (rsp.res_re !== want.res_re)
                        report_mismatch("res_re", rsp.res_re, want.res_re);
                    if (rsp.res_im !== want.res_im)
                        report_mismatch("res_im", rsp.res_im, want.res_im);
                    if (rsp.status !== want.status)
                        report_mismatch("status", rsp.status, want.status);
                end
            end
        end
    end

endmodule

FILE: tb/complex_arithmetic_unit_test.sv
`timescale 1ns / 1ps

module complex_arithmetic_unit_test;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    cau_pkg::req_t cmd;
    logic          done;
    cau_pkg::rsp_t rsp;
    int            errors;
    int            pending;
    int            results_seen;
    int            sent;

    localparam int LATENCY = cau_pkg::DATA_W + 4;

    complex_arithmetic_unit i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .cmd  (cmd),
        .done (done),
        .rsp  (rsp)
    );

    complex_arithmetic_unit_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .done        (done),
        .rsp         (rsp),
        .errors      (errors),
        .pending     (pending),
        .results_seen(results_seen)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic [cau_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return '0;
            3: return 16'(int'($urandom_range(0, 1023)) - 512);
            4: return 16'(int'($urandom_range(0, 127)) - 64);
            default: return 16'($urandom);
        endcase
    endfunction

    // holds start for one accepted beat, then drops it unless another follows
    task automatic send_beat(cau_pkg::op_t op, logic [cau_pkg::DATA_W-1:0] ar,
                             logic [cau_pkg::DATA_W-1:0] ai,
                             logic [cau_pkg::DATA_W-1:0] br,
                             logic [cau_pkg::DATA_W-1:0] bi);
        int gap;
        begin
            start        <= 1'b1;
            cmd.req_type <= op;
            cmd.a_re     <= ar;
            cmd.a_im     <= ai;
            cmd.b_re     <= br;
            cmd.b_im     <= bi;
            do
                @(posedge clk);
            while (busy);
            sent++;
            @(negedge clk);
            gap = ($urandom_range(0, 3) == 0) ?
                  (($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3)) : 0;
            if (gap > 0)
            begin
                start        <= 1'b0;
                cmd.req_type <= 2'($urandom);
                cmd.a_re     <= 16'($urandom);
                cmd.a_im     <= 16'($urandom);
                cmd.b_re     <= 16'($urandom);
                cmd.b_im     <= 16'($urandom);
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    initial
    begin
        cau_pkg::op_t op;
        start = 1'b0;
        cmd   = '0;
        rst_n = 1'b0;
        sent  = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int k = 0; k < 4; k++)
        begin
            op = cau_pkg::op_t'(k);
            send_beat(op, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
            send_beat(op, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
            send_beat(op, 16'h0100, 16'hff00, 16'h0000, 16'h0000);
            send_beat(op, 16'hffff, 16'h0001, 16'h0080, 16'hff80);
        end
        send_beat(cau_pkg::OP_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);
        send_beat(cau_pkg::OP_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_beat(cau_pkg::OP_MUL, 16'hffff, 16'hffff, 16'h0001, 16'h0001);
        send_beat(cau_pkg::OP_DIV, 16'h0300, 16'hfd00, 16'h0200, 16'h0000);

        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);

        for (int n = 0; n < 650; n++)
        begin
            op = cau_pkg::op_t'($urandom_range(0, 3));
            if ($urandom_range(0, 30) == 0)
                send_beat(cau_pkg::OP_DIV, pick_value(), pick_value(), '0, '0);
            else
                send_beat(op, pick_value(), pick_value(), pick_value(), pick_value());
        end
        start <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
        $display("Sent %0d commands over all four operations, %0d results checked.",
                 sent, results_seen);
        if (errors == 0 && pending == 0)
            $display("complex_arithmetic_unit test passed");
        else
            $display("complex_arithmetic_unit test failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("complex_arithmetic_unit test failed");
        $finish;
    end

endmodule
